### sv/olpe_pkg.sv
// ---------------------------------------------------------------------------
// olpe_pkg: shared definitions for the ordered list positional engine
// Field widths, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package olpe_pkg;

    // Default list capacity.
    localparam int DEPTH_DEFAULT = 64;

    // Fixed field widths of a request and a result.
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // Operation codes carried in func.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Update applied to the entry pointer.
    typedef enum logic [2:0] {
        IDX_HOLD  = 3'd0,
        IDX_COUNT = 3'd1,
        IDX_POS   = 3'd2,
        IDX_ZERO  = 3'd3,
        IDX_INC   = 3'd4,
        IDX_DEC   = 3'd5
    } olpe_idx_op_t;

    // Read address relative to the entry pointer.
    typedef enum logic [1:0] {
        RD_AT    = 2'd0,
        RD_BELOW = 2'd1,
        RD_ABOVE = 2'd2
    } olpe_rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  load_req;
        olpe_idx_op_t          idx_op;
        logic                  rd_en;
        olpe_rd_sel_t          rd_sel;
        logic                  wr_en;
        logic                  wr_value;
        logic                  save_data;
        logic                  set_status;
        logic [STATUS_W-1:0]   status_code;
        logic                  set_found;
        logic                  count_inc;
        logic                  count_dec;
        logic                  count_clr;
        logic                  out_load;
    } olpe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic              ins_pos_ok;
        logic              rd_pos_ok;
        logic              full;
        logic              ins_more;
        logic              del_more;
        logic              find_more;
        logic              match;
    } olpe_stat_t;

endpackage

### sv/olpe_datapath.sv
// ---------------------------------------------------------------------------
// olpe_datapath: entry memory, request registers and result registers
// Holds the list entries in a single-port-read, single-port-write memory,
// moves one entry per command pair and reports compare flags to the control.
// ---------------------------------------------------------------------------
module olpe_datapath #(
    parameter int DEPTH = olpe_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [olpe_pkg::FUNC_W-1:0]           func,
    input  logic [olpe_pkg::POS_W-1:0]            position,
    input  logic signed [olpe_pkg::VAL_W-1:0]     value,
    input  olpe_pkg::olpe_cmd_t                   cmd,
    output olpe_pkg::olpe_stat_t                  stat,
    output logic [olpe_pkg::STATUS_W-1:0]         status,
    output logic signed [olpe_pkg::VAL_W-1:0]     data_out,
    output logic [olpe_pkg::POS_W-1:0]            found_position,
    output logic [olpe_pkg::LEN_W-1:0]            length
);
    import olpe_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Entry storage.
    logic [VAL_W-1:0]           entries_mem [DEPTH];
    logic [VAL_W-1:0]           rd_data_reg;

    // Request registers.
    logic [FUNC_W-1:0]          func_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [VAL_W-1:0]           val_reg;

    // Control registers.
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [CW-1:0]              idx_reg;
    logic [CW-1:0]              idx_next;

    // Working result and output registers.
    logic [STATUS_W-1:0]        res_status_reg;
    logic [VAL_W-1:0]           res_data_reg;
    logic [POS_W-1:0]           res_fpos_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [VAL_W-1:0]           data_out_reg;
    logic [POS_W-1:0]           fpos_reg;
    logic [LEN_W-1:0]           length_reg;

    logic [CW-1:0]              idx_dn;
    logic [CW-1:0]              idx_up;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [VAL_W-1:0]           wr_data;
    logic [CMPW-1:0]            pos_w;
    logic [CMPW-1:0]            cnt_w;
    logic [CMPW-1:0]            idx_w;

    // Neighbor addresses of the entry pointer.
    assign idx_dn  = idx_reg - CW'(1);
    assign idx_up  = idx_reg + CW'(1);
    assign wr_addr = idx_reg[AW-1:0];
    assign wr_data = cmd.wr_value ? val_reg : rd_data_reg;

    // Read address select.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_BELOW: rd_addr = idx_dn[AW-1:0];
            RD_ABOVE: rd_addr = idx_up[AW-1:0];
            default:  rd_addr = idx_reg[AW-1:0];
        endcase
    end

    // Entry memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            entries_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entries_mem[rd_addr];
        end
    end

    // Request capture on an input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= func;
            pos_reg  <= position;
            val_reg  <= value;
        end
    end

    // Length and entry pointer updates.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_clr)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_COUNT: idx_next = count_reg;
            IDX_POS:   idx_next = CW'(pos_w - CMPW'(1));
            IDX_ZERO:  idx_next = '0;
            IDX_INC:   idx_next = idx_up;
            IDX_DEC:   idx_next = idx_dn;
            default:   idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Working result, cleared when a request is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            res_status_reg <= ST_OK;
            res_data_reg   <= '0;
            res_fpos_reg   <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.save_data)
            begin
                res_data_reg <= rd_data_reg;
            end
            if (cmd.set_found)
            begin
                res_fpos_reg <= POS_W'(idx_up);
            end
        end
    end

    // Output register, loaded when the result is handed over.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg   <= res_status_reg;
            data_out_reg <= res_data_reg;
            fpos_reg     <= res_fpos_reg;
            length_reg   <= LEN_W'(count_reg);
        end
    end

    assign status         = status_reg;
    assign data_out       = data_out_reg;
    assign found_position = fpos_reg;
    assign length         = length_reg;

    // Compare flags for the controller.
    assign pos_w = CMPW'(pos_reg);
    assign cnt_w = CMPW'(count_reg);
    assign idx_w = CMPW'(idx_reg);

    assign stat.op         = func_reg;
    assign stat.ins_pos_ok = (pos_reg != '0) && (pos_w <= cnt_w + CMPW'(1));
    assign stat.rd_pos_ok  = (pos_reg != '0) && (pos_w <= cnt_w);
    assign stat.full       = (cnt_w == CMPW'(DEPTH));
    assign stat.ins_more   = (idx_w >= pos_w);
    assign stat.del_more   = (idx_w + CMPW'(1) < cnt_w);
    assign stat.find_more  = (idx_w < cnt_w);
    assign stat.match      = (rd_data_reg == val_reg);

endmodule

### sv/olpe_control.sv
// ---------------------------------------------------------------------------
// olpe_control: sequencer of the ordered list positional engine
// Accepts one request at a time, steps the datapath through the shift,
// read and search loops, and owns the output valid flag.
// ---------------------------------------------------------------------------
module olpe_control (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  olpe_pkg::olpe_stat_t  stat,
    output olpe_pkg::olpe_cmd_t   cmd
);
    import olpe_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE       = 16'b0000_0000_0000_0001,
        S_DECODE     = 16'b0000_0000_0000_0010,
        S_INS_CHK    = 16'b0000_0000_0000_0100,
        S_INS_RD     = 16'b0000_0000_0000_1000,
        S_INS_WR     = 16'b0000_0000_0001_0000,
        S_INS_PUT    = 16'b0000_0000_0010_0000,
        S_ENTRY_RD   = 16'b0000_0000_0100_0000,
        S_ENTRY_SAVE = 16'b0000_0000_1000_0000,
        S_DEL_CHK    = 16'b0000_0001_0000_0000,
        S_DEL_RD     = 16'b0000_0010_0000_0000,
        S_DEL_WR     = 16'b0000_0100_0000_0000,
        S_DEL_END    = 16'b0000_1000_0000_0000,
        S_FIND_CHK   = 16'b0001_0000_0000_0000,
        S_FIND_RD    = 16'b0010_0000_0000_0000,
        S_FIND_CMP   = 16'b0100_0000_0000_0000,
        S_FINISH     = 16'b1000_0000_0000_0000
    } olpe_state_t;

    olpe_state_t state_reg;
    olpe_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // New requests are taken only between operations.
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.idx_op      = IDX_HOLD;
        cmd.rd_sel      = RD_AT;
        cmd.status_code = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (stat.op) inside
                    FUNC_INSERT:
                    begin
                        if (!stat.ins_pos_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BADPOS;
                            state_next      = S_FINISH;
                        end
                        else if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                            state_next = S_INS_CHK;
                        end
                    end
                    FUNC_DELETE, FUNC_GET:
                    begin
                        if (!stat.rd_pos_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BADPOS;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_ENTRY_RD;
                        end
                    end
                    FUNC_FIND:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_FIND_CHK;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.count_clr = 1'b1;
                        state_next    = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // Insert: move entries back from the tail down to the position.
            S_INS_CHK:
            begin
                state_next = stat.ins_more ? S_INS_RD : S_INS_PUT;
            end

            S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_BELOW;
                state_next = S_INS_WR;
            end

            S_INS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_DEC;
                state_next = S_INS_CHK;
            end

            S_INS_PUT:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_value  = 1'b1;
                cmd.count_inc = 1'b1;
                state_next    = S_FINISH;
            end

            // Get and delete: read the addressed entry.
            S_ENTRY_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT;
                state_next = S_ENTRY_SAVE;
            end

            S_ENTRY_SAVE:
            begin
                cmd.save_data = 1'b1;
                state_next    = (stat.op == FUNC_DELETE) ? S_DEL_CHK : S_FINISH;
            end

            // Delete: move later entries forward by one.
            S_DEL_CHK:
            begin
                state_next = stat.del_more ? S_DEL_RD : S_DEL_END;
            end

            S_DEL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ABOVE;
                state_next = S_DEL_WR;
            end

            S_DEL_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = S_DEL_CHK;
            end

            S_DEL_END:
            begin
                cmd.count_dec = 1'b1;
                state_next    = S_FINISH;
            end

            // Find: scan from the head until a match or the tail.
            S_FIND_CHK:
            begin
                if (stat.find_more)
                begin
                    state_next = S_FIND_RD;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOTFOUND;
                    state_next      = S_FINISH;
                end
            end

            S_FIND_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT;
                state_next = S_FIND_CMP;
            end

            S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_FIND_CHK;
                end
            end

            // Hand the result to the output register once it is free.
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a load, cleared by an output transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/ordered_list_positional_engine.sv
// Throughput: one request at a time; the next can be taken in the cycle after the
// result is loaded. The pace is set by the entry memory, which moves or compares
// one entry per check, read and write (or compare) state sequence.
// Reset: asynchronous, clears length and control; entries are not cleared.
// ---------------------------------------------------------------------------
// ordered_list_positional_engine: top level
// Bounded ordered list of signed words addressed by 1-based position, with
// insert, delete, get, find and clear requests and one result per request.
// ---------------------------------------------------------------------------
module ordered_list_positional_engine #(
    parameter int DEPTH = olpe_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [olpe_pkg::FUNC_W-1:0]           func,
    input  logic [olpe_pkg::POS_W-1:0]            position,
    input  logic signed [olpe_pkg::VAL_W-1:0]     value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [olpe_pkg::STATUS_W-1:0]         status,
    output logic signed [olpe_pkg::VAL_W-1:0]     data_out,
    output logic [olpe_pkg::POS_W-1:0]            found_position,
    output logic [olpe_pkg::LEN_W-1:0]            length
);
    import olpe_pkg::*;

    olpe_cmd_t  cmd;
    olpe_stat_t stat;

    // Sequencer.
    olpe_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Entry storage and result path.
    olpe_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .func           (func),
        .position       (position),
        .value          (value),
        .cmd            (cmd),
        .stat           (stat),
        .status         (status),
        .data_out       (data_out),
        .found_position (found_position),
        .length         (length)
    );

endmodule

### sv/olpe_checker.sv
// ---------------------------------------------------------------------------
// olpe_checker: port-level checks for the ordered list positional engine
// Watches the request and result channels and checks result consistency.
// ---------------------------------------------------------------------------
module olpe_checker #(
    parameter int DEPTH = olpe_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [olpe_pkg::STATUS_W-1:0]         status,
    input  logic signed [olpe_pkg::VAL_W-1:0]     data_out,
    input  logic [olpe_pkg::POS_W-1:0]            found_position,
    input  logic [olpe_pkg::LEN_W-1:0]            length
);
    import olpe_pkg::*;

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_out)
            && $stable(found_position) && $stable(length))
        else $error("result changed while stalled");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while another is in progress");

    // Reported length never exceeds the capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 127) || (length <= LEN_W'(DEPTH)))
        else $error("length above capacity");

    // A full report comes only with a full list.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (length == LEN_W'(DEPTH)))
        else $error("full status with list not full");

    // A found position is reported only with an ok status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (found_position != '0) |-> (status == ST_OK))
        else $error("found position with failing status");

endmodule

bind ordered_list_positional_engine olpe_checker #(
    .DEPTH (DEPTH)
) u_olpe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .data_out       (data_out),
    .found_position (found_position),
    .length         (length)
);
